// File: rtl/amicable_pair_check_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the amicable pair checker
// Shared forms for concurrent checks clocked on aclk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef AMICABLE_PAIR_CHECK_TOP_ASSERT_SVH
`define AMICABLE_PAIR_CHECK_TOP_ASSERT_SVH

// Same-cycle implication
`define APC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define APC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/apc_pkg.sv
// ----------------------------------------------------------------------------
// Amicable pair checker package
// Fixed result widths and the sequencer state encoding.
// ----------------------------------------------------------------------------
package apc_pkg;

    // Width of the reported divisor sums
    localparam int SUM_BITS = 27;
    localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

    // Sequencer states, one-hot
    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_CHECK   = 7'b0000010,
        ST_DIVIDE  = 7'b0000100,
        ST_ADD_DIV = 7'b0001000,
        ST_ADD_CO  = 7'b0010000,
        ST_STEP    = 7'b0100000,
        ST_DONE    = 7'b1000000
    } apc_state_t;

endpackage

// File: rtl/apc_serial_div.sv
// ----------------------------------------------------------------------------
// Serial restoring divider
// Produces one quotient bit per cycle; done pulses once when the quotient
// and remainder are valid. Results hold until the next start.
// ----------------------------------------------------------------------------
module apc_serial_div #(
    parameter int DIVIDEND_BITS = 24,
    parameter int DIVISOR_BITS  = 13
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [DIVIDEND_BITS-1:0] dividend,
    input  logic [DIVISOR_BITS-1:0]  divisor,
    output logic                     done,
    output logic [DIVIDEND_BITS-1:0] quotient,
    output logic [DIVISOR_BITS-1:0]  remainder
);

    localparam int COUNT_BITS = $clog2(DIVIDEND_BITS + 1);

    logic                     busy_reg,  busy_next;
    logic                     done_reg,  done_next;
    logic [COUNT_BITS-1:0]    count_reg, count_next;
    logic [DIVIDEND_BITS-1:0] quot_reg,  quot_next;
    logic [DIVISOR_BITS-1:0]  rem_reg,   rem_next;
    logic [DIVISOR_BITS:0]    trial;
    logic [DIVISOR_BITS:0]    diff;
    logic                     fits;

    // Shift the next dividend bit into the partial remainder and try a subtract
    assign trial = {rem_reg, quot_reg[DIVIDEND_BITS-1]};
    assign diff  = trial - {1'b0, divisor};
    assign fits  = (trial >= {1'b0, divisor});

    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        if (start) begin
            busy_next  = 1'b1;
            count_next = COUNT_BITS'(DIVIDEND_BITS);
            quot_next  = dividend;
            rem_next   = '0;
        end else if (busy_reg) begin
            quot_next  = {quot_reg[DIVIDEND_BITS-2:0], fits};
            rem_next   = fits ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
            count_next = count_reg - COUNT_BITS'(1);
            if (count_reg == COUNT_BITS'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule

// File: rtl/amicable_pair_check_top.sv
// ----------------------------------------------------------------------------
// Amicable pair checker
// Sums the proper divisors of two numbers by trial division and flags the
// pair when each sum equals the other number and the numbers differ.
//
//   Channel  Direction  Handshake           Payload
//   s_       in         s_valid / s_ready   s_first_number, s_second_number
//   m_       out        m_valid / m_ready   m_first_divisor_sum,
//                                           m_second_divisor_sum, m_is_amicable
//
// Each candidate divisor d (2 while d*d <= n) passes through CHECK, DIVIDE and
// STEP, with ADD_DIV when it divides n and ADD_CO when n/d also differs from d.
// Reset is synchronous, active low; it clears the sequencer and output valid.
// s_ready is high only between requests; a result waiting on m_ready does
// not block the next request, which stalls only at its own finish.
// ----------------------------------------------------------------------------
`include "amicable_pair_check_top_assert.svh"

module amicable_pair_check_top #(
    parameter int NUMBER_BITS = 24
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [NUMBER_BITS-1:0]        s_first_number,
    input  logic [NUMBER_BITS-1:0]        s_second_number,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [apc_pkg::SUM_BITS-1:0]  m_first_divisor_sum,
    output logic [apc_pkg::SUM_BITS-1:0]  m_second_divisor_sum,
    output logic                          m_is_amicable
);

    import apc_pkg::*;

    localparam int EXACT_BITS = NUMBER_BITS + 3;
    localparam int D_BITS     = (NUMBER_BITS + 1) / 2 + 1;
    localparam int SQ_BITS    = NUMBER_BITS + 1;
    localparam int WIDE_BITS  = (EXACT_BITS > SUM_BITS) ? EXACT_BITS : SUM_BITS;
    localparam int SQ_CHK_BITS = 2 * D_BITS;

    apc_state_t               state_reg, state_next;
    logic                     sel_reg,   sel_next;
    logic [NUMBER_BITS-1:0]   first_reg, first_next;
    logic [NUMBER_BITS-1:0]   second_reg, second_next;
    logic [EXACT_BITS-1:0]    sum_a_reg, sum_a_next;
    logic [EXACT_BITS-1:0]    total_reg, total_next;
    logic [D_BITS-1:0]        d_reg,     d_next;
    logic [SQ_BITS-1:0]       sq_reg,    sq_next;

    logic                     m_valid_reg, m_valid_next;
    logic [SUM_BITS-1:0]      m_sum_a_reg, m_sum_a_next;
    logic [SUM_BITS-1:0]      m_sum_b_reg, m_sum_b_next;
    logic                     m_pair_reg,  m_pair_next;

    logic [NUMBER_BITS-1:0]   cur_n;
    logic [NUMBER_BITS-1:0]   next_n;
    logic                     div_start;
    logic                     div_done;
    logic [NUMBER_BITS-1:0]   div_quot;
    logic [D_BITS-1:0]        div_rem;
    logic [WIDE_BITS-1:0]     wide_a;
    logic [WIDE_BITS-1:0]     wide_b;
    logic [SUM_BITS-1:0]      sat_a;
    logic [SUM_BITS-1:0]      sat_b;
    logic                     pair_hit;

    // Shared divider: n / d, one bit a cycle
    apc_serial_div #(
        .DIVIDEND_BITS (NUMBER_BITS),
        .DIVISOR_BITS  (D_BITS)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (cur_n),
        .divisor   (d_reg),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    assign cur_n  = sel_reg ? second_reg : first_reg;
    assign next_n = second_reg;

    // Saturate the exact sums to the reported width
    assign wide_a = WIDE_BITS'(sum_a_reg);
    assign wide_b = WIDE_BITS'(total_reg);
    assign sat_a  = (wide_a > WIDE_BITS'(SUM_MAX)) ? SUM_MAX : wide_a[SUM_BITS-1:0];
    assign sat_b  = (wide_b > WIDE_BITS'(SUM_MAX)) ? SUM_MAX : wide_b[SUM_BITS-1:0];

    // Compare exact sums against the other number
    assign pair_hit = (sum_a_reg == EXACT_BITS'(second_reg)) &&
                      (total_reg == EXACT_BITS'(first_reg)) &&
                      (first_reg != second_reg);

    assign s_ready = (state_reg == ST_IDLE);

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        sel_next     = sel_reg;
        first_next   = first_reg;
        second_next  = second_reg;
        sum_a_next   = sum_a_reg;
        total_next   = total_reg;
        d_next       = d_reg;
        sq_next      = sq_reg;
        m_valid_next = m_valid_reg;
        m_sum_a_next = m_sum_a_reg;
        m_sum_b_next = m_sum_b_reg;
        m_pair_next  = m_pair_reg;
        div_start    = 1'b0;

        // Drop the result once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    first_next  = s_first_number;
                    second_next = s_second_number;
                    sel_next    = 1'b0;
                    total_next  = (s_first_number >= NUMBER_BITS'(2)) ?
                                  EXACT_BITS'(1) : '0;
                    d_next      = D_BITS'(2);
                    sq_next     = SQ_BITS'(4);
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (sq_reg > SQ_BITS'(cur_n)) begin
                    if (!sel_reg) begin
                        // Switch to the second number
                        sum_a_next = total_reg;
                        sel_next   = 1'b1;
                        total_next = (next_n >= NUMBER_BITS'(2)) ?
                                     EXACT_BITS'(1) : '0;
                        d_next     = D_BITS'(2);
                        sq_next    = SQ_BITS'(4);
                    end else begin
                        state_next = ST_DONE;
                    end
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (div_done) begin
                    state_next = (div_rem == '0) ? ST_ADD_DIV : ST_STEP;
                end
            end
            ST_ADD_DIV: begin
                total_next = total_reg + EXACT_BITS'(d_reg);
                state_next = (div_quot != NUMBER_BITS'(d_reg)) ? ST_ADD_CO : ST_STEP;
            end
            ST_ADD_CO: begin
                total_next = total_reg + EXACT_BITS'(div_quot);
                state_next = ST_STEP;
            end
            ST_STEP: begin
                // Advance d and keep sq at d*d
                sq_next    = sq_reg + SQ_BITS'({d_reg, 1'b1});
                d_next     = d_reg + D_BITS'(1);
                state_next = ST_CHECK;
            end
            ST_DONE: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_sum_a_next = sat_a;
                    m_sum_b_next = sat_b;
                    m_pair_next  = pair_hit;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            sel_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sel_reg     <= sel_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        first_reg   <= first_next;
        second_reg  <= second_next;
        sum_a_reg   <= sum_a_next;
        total_reg   <= total_next;
        d_reg       <= d_next;
        sq_reg      <= sq_next;
        m_sum_a_reg <= m_sum_a_next;
        m_sum_b_reg <= m_sum_b_next;
        m_pair_reg  <= m_pair_next;
    end

    assign m_valid              = m_valid_reg;
    assign m_first_divisor_sum  = m_sum_a_reg;
    assign m_second_divisor_sum = m_sum_b_reg;
    assign m_is_amicable        = m_pair_reg;

    // Checks
    `APC_ASSERT_IMP(a_div_done_in_divide, div_done, state_reg == ST_DIVIDE, "divider done outside divide")
    `APC_ASSERT_IMP(a_sq_tracks_d, state_reg == ST_CHECK, SQ_CHK_BITS'(sq_reg) == SQ_CHK_BITS'(d_reg) * SQ_CHK_BITS'(d_reg), "square out of step with candidate")
    `APC_ASSERT_NXT(a_sum_grows, state_reg == ST_ADD_DIV, total_reg > $past(total_reg), "divisor add did not grow the sum")
    `APC_ASSERT_NXT(a_done_loads, state_reg == ST_DONE && (!m_valid_reg || m_ready), m_valid_reg && state_reg == ST_IDLE, "finished request not loaded")

endmodule

// File: sim/amicable_pair_check_top_tb.sv
// ----------------------------------------------------------------------------
// Amicable pair checker testbench
// Drives number pairs into amicable_pair_check_top and checks every returned
// pair of divisor sums and the amicable flag against a local trial-division
// predictor, or the listed sums of typed rows. A short table of hand-picked
// pairs comes first, then random pairs, with random idle gaps on the request
// side and random back-pressure on the result side.
// ----------------------------------------------------------------------------
module amicable_pair_check_top_tb;

    localparam int NUM_W = 24;
    localparam int SUM_W = apc_pkg::SUM_BITS;
    localparam int RANDOM_REQUESTS = 100;
    localparam int DIR_ROWS = 17;
    localparam int DRAIN_CYCLES = 500;
    localparam int LONG_HOLD_CYCLES = 50000;
    localparam int LONG_HOLD_AT = 30;

    typedef struct packed {
        logic [SUM_W-1:0] first_sum;
        logic [SUM_W-1:0] second_sum;
        logic             pair;
    } divisor_sums_t;

    typedef struct packed {
        logic [NUM_W-1:0] first_number;
        logic [NUM_W-1:0] second_number;
        logic             typed;
        divisor_sums_t    sums;
    } pair_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [NUM_W-1:0]     s_first_number;
    logic [NUM_W-1:0]     s_second_number;
    logic                 m_valid;
    logic                 m_ready;
    logic [SUM_W-1:0]     m_first_divisor_sum;
    logic [SUM_W-1:0]     m_second_divisor_sum;
    logic                 m_is_amicable;

    divisor_sums_t        sums_due[$];
    int                   mismatch_count = 0;
    int                   sums_checked = 0;

    // Known amicable pairs, used to build well-formed requests
    int amicable_lo [8] = '{220, 1184, 2620, 5020, 6232, 10744, 12285, 17296};
    int amicable_hi [8] = '{284, 1210, 2924, 5564, 6368, 10856, 14595, 18416};
    int perfect_nums [4] = '{6, 28, 496, 8128};

    // Hand-picked pairs; typed rows carry their expected sums
    pair_row_t dir_rows [DIR_ROWS] = '{
        '{24'd1,        24'd1,        1'b1, '{27'd0,    27'd0,    1'b0}},
        '{24'd0,        24'd1,        1'b1, '{27'd0,    27'd0,    1'b0}},
        '{24'd1,        24'd0,        1'b1, '{27'd0,    27'd0,    1'b0}},
        '{24'd2,        24'd3,        1'b1, '{27'd1,    27'd1,    1'b0}},
        '{24'd2,        24'd2,        1'b1, '{27'd1,    27'd1,    1'b0}},
        '{24'd220,      24'd284,      1'b1, '{27'd284,  27'd220,  1'b1}},
        '{24'd284,      24'd220,      1'b1, '{27'd220,  27'd284,  1'b1}},
        '{24'd1184,     24'd1210,     1'b1, '{27'd1210, 27'd1184, 1'b1}},
        '{24'd5020,     24'd5564,     1'b1, '{27'd5564, 27'd5020, 1'b1}},
        '{24'd6,        24'd6,        1'b1, '{27'd6,    27'd6,    1'b0}},
        '{24'd4,        24'd9,        1'b0, '0},
        '{24'd28,       24'd496,      1'b0, '0},
        '{24'd220,      24'd220,      1'b0, '0},
        '{24'd220,      24'd285,      1'b0, '0},
        '{24'd2520,     24'd65536,    1'b0, '0},
        '{24'd16777215, 24'd1,        1'b0, '0},
        '{24'd1,        24'd16777215, 1'b0, '0}
    };

    amicable_pair_check_top #(
        .NUMBER_BITS (NUM_W)
    ) u_dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_first_number       (s_first_number),
        .s_second_number      (s_second_number),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_first_divisor_sum  (m_first_divisor_sum),
        .m_second_divisor_sum (m_second_divisor_sum),
        .m_is_amicable        (m_is_amicable)
    );

    // Free-running clock, period 10
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Sum of proper divisors by trial division, exact width
    function automatic longint unsigned aliquot_sum(input logic [NUM_W-1:0] n);
        longint unsigned total;
        longint unsigned d;
        longint unsigned value;
        value = n;
        if (value < 2) begin
            return 0;
        end
        total = 1;
        for (d = 2; d * d <= value; d++) begin
            if (value % d == 0) begin
                total += d;
                if (value / d != d) begin
                    total += value / d;
                end
            end
        end
        return total;
    endfunction

    // Expected sums and flag for one request; flag uses the unclamped sums
    function automatic divisor_sums_t predict_sums(input logic [NUM_W-1:0] a,
                                                   input logic [NUM_W-1:0] b);
        divisor_sums_t    res;
        longint unsigned  sa;
        longint unsigned  sb;
        sa = aliquot_sum(a);
        sb = aliquot_sum(b);
        res.first_sum  = (sa > apc_pkg::SUM_MAX) ? apc_pkg::SUM_MAX : sa[SUM_W-1:0];
        res.second_sum = (sb > apc_pkg::SUM_MAX) ? apc_pkg::SUM_MAX : sb[SUM_W-1:0];
        res.pair       = (sa == longint'(b)) && (sb == longint'(a)) && (a != b);
        return res;
    endfunction

    // Random number of up to max_bits bits, never zero
    function automatic logic [NUM_W-1:0] rand_number(input int max_bits);
        int w;
        w = $urandom_range(1, max_bits);
        return NUM_W'($urandom_range(1, (1 << w) - 1));
    endfunction

    // Request-side gap: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(20, 200);
    endfunction

    // Result-side stall: mostly none or short, a few long
    function automatic int pick_stall();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(15, 120);
    endfunction

    // Random pair: mostly well-formed pairs and near misses, some noise
    task automatic pick_random_pair(output logic [NUM_W-1:0] a,
                                    output logic [NUM_W-1:0] b);
        int               r;
        int               k;
        longint unsigned  s;
        r = $urandom_range(0, 99);
        if (r < 20) begin
            // known amicable pair, either order
            k = $urandom_range(0, 7);
            if ($urandom_range(0, 1) == 1) begin
                a = NUM_W'(amicable_lo[k]);
                b = NUM_W'(amicable_hi[k]);
            end else begin
                a = NUM_W'(amicable_hi[k]);
                b = NUM_W'(amicable_lo[k]);
            end
        end else if (r < 28) begin
            // perfect number against itself or another
            a = NUM_W'(perfect_nums[$urandom_range(0, 3)]);
            b = ($urandom_range(0, 1) == 1) ? a : NUM_W'(perfect_nums[$urandom_range(0, 3)]);
        end else if (r < 50) begin
            // one number is the aliquot sum of the other
            a = rand_number(14);
            s = aliquot_sum(a);
            b = (s == 0) ? rand_number(12) : NUM_W'(s);
            if ($urandom_range(0, 1) == 1) begin
                {a, b} = {b, a};
            end
        end else if (r < 90) begin
            a = rand_number(12);
            b = rand_number(12);
        end else if (r < 96) begin
            a = rand_number(17);
            b = rand_number(17);
        end else begin
            // equal numbers and ones
            a = rand_number(10);
            b = ($urandom_range(0, 1) == 1) ? a : 24'd1;
        end
    endtask

    // Offer one request, hold it until accepted, then record its expectation
    task automatic offer(input logic [NUM_W-1:0] a, input logic [NUM_W-1:0] b,
                         input logic typed, input divisor_sums_t typed_sums);
        s_valid         <= 1'b1;
        s_first_number  <= a;
        s_second_number <= b;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        if (typed) begin
            sums_due.push_back(typed_sums);
        end else begin
            sums_due.push_back(predict_sums(a, b));
        end
    endtask

    // Drop valid for a random gap after an accepted request
    task automatic idle_after_request(input bit burst);
        int gap;
        gap = burst ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Compare one accepted result with the oldest expectation
    task automatic check_result();
        divisor_sums_t want;
        if (sums_due.size() == 0) begin
            $display("%0t: unexpected result sums %0d %0d flag %0b", $time,
                     m_first_divisor_sum, m_second_divisor_sum, m_is_amicable);
            mismatch_count++;
        end else begin
            want = sums_due.pop_front();
            if (m_first_divisor_sum !== want.first_sum) begin
                $display("%0t: first_divisor_sum expected %0d actual %0d", $time,
                         want.first_sum, m_first_divisor_sum);
                mismatch_count++;
            end
            if (m_second_divisor_sum !== want.second_sum) begin
                $display("%0t: second_divisor_sum expected %0d actual %0d", $time,
                         want.second_sum, m_second_divisor_sum);
                mismatch_count++;
            end
            if (m_is_amicable !== want.pair) begin
                $display("%0t: is_amicable expected %0b actual %0b", $time,
                         want.pair, m_is_amicable);
                mismatch_count++;
            end
        end
        sums_checked++;
    endtask

    // Request side: reset, table, pause, random pairs, drain
    initial begin : request_side
        logic [NUM_W-1:0] a;
        logic [NUM_W-1:0] b;
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_first_number  = '0;
        s_second_number = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            offer(dir_rows[i].first_number, dir_rows[i].second_number,
                  dir_rows[i].typed, dir_rows[i].sums);
            idle_after_request(1'b0);
        end

        // Hold off until every result so far has come back
        s_valid <= 1'b0;
        while (sums_due.size() != 0) @(posedge aclk);

        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            pick_random_pair(a, b);
            offer(a, b, 1'b0, '0);
            idle_after_request(i >= 30 && i < 45);
        end

        // Drain, then watch for stray results
        s_valid <= 1'b0;
        while (sums_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("amicable_pair_check_top_tb: done, clean");
        end else begin
            $display("amicable_pair_check_top_tb: done, errors");
        end
        $finish;
    end

    // Result side: check accepted results and apply back-pressure
    initial begin : result_side
        int hold;
        bit long_hold_done;
        hold           = 0;
        long_hold_done = 1'b0;
        m_ready        = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                check_result();
            end
            if (!long_hold_done && sums_checked == LONG_HOLD_AT) begin
                // hold off long enough for the block to back up its input
                hold           = LONG_HOLD_CYCLES;
                long_hold_done = 1'b1;
            end else if (hold == 0 && !(sums_checked >= 55 && sums_checked < 70)) begin
                hold = pick_stall();
            end
            if (hold > 0) begin
                m_ready <= 1'b0;
                hold--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // End a hung run
    initial begin : watchdog
        #200_000_000;
        $display("amicable_pair_check_top_tb: done, errors");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/apc_pkg.sv
rtl/apc_serial_div.sv
rtl/amicable_pair_check_top.sv
sim/amicable_pair_check_top_tb.sv
